// File: hw/rtl/framed_serial_dimmer_controller_macros.svh
// Assertion macros shared by the dimmer controller RTL.
`ifndef FRAMED_SERIAL_DIMMER_CONTROLLER_MACROS_SVH
`define FRAMED_SERIAL_DIMMER_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define FSDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dimmer controller check failed");
// Next-cycle implication.
`define FSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dimmer controller check failed");
`else
`define FSDC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/fsdc_pkg.sv
// Types and constants of the framed serial dimmer controller.
package fsdc_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [7:0] pot_value;
        logic       switch_on;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  duty;
        logic        frame_valid;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic [15:0] error_count;
    } out_item_t;

    typedef struct packed {
        logic [9:0] adc_period_ms;
        logic [9:0] fade_period_ms;
        logic [6:0] fade_step;
    } cfg_t;

    // One processed request as handed to the transmit stage.
    typedef struct packed {
        logic        report;
        logic [7:0]  value;
        logic [7:0]  duty;
        logic [15:0] error_count;
    } run_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_SIZE = 3'd1,
        PH_CMD  = 3'd2,
        PH_DATA = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_POT  = 2'd2;

    localparam logic [7:0] CMD_REPORT_POT  = 8'd0;
    localparam logic [7:0] CMD_SET_DUTY    = 8'd1;
    localparam logic [7:0] CMD_SET_SLEEP   = 8'd2;
    localparam logic [7:0] CMD_REPORT_DUTY = 8'd3;

    localparam logic [7:0] SLEEP_OFF  = 8'd0;
    localparam logic [7:0] SLEEP_FULL = 8'd1;
    localparam logic [7:0] SLEEP_FADE = 8'd2;
    localparam logic [7:0] SLEEP_MIN  = 8'd3;

    localparam logic [1:0] CFG_ADC_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_FADE_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FADE_STEP   = 2'd2;

    localparam logic [9:0] ADC_PERIOD_RST  = 10'd25;
    localparam logic [9:0] FADE_PERIOD_RST = 10'd50;
    localparam logic [6:0] FADE_STEP_RST   = 7'd1;
    localparam logic [8:0] FADE_INC_RST    = 9'd5;

    localparam logic [7:0] START_MARK  = 8'h3C;
    localparam logic [7:0] END_MARK    = 8'h3E;
    localparam logic [7:0] REPORT_SIZE = 8'd1;
    localparam logic [7:0] REPORT_CMD  = 8'd0;
    localparam logic [7:0] DUTY_MAX    = 8'd255;

    localparam logic [2:0] REPORT_LAST_IDX = 3'd4;

    // Byte of a report frame at position idx.
    function automatic logic [7:0] report_byte(input logic [2:0] idx, input logic [7:0] value);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = START_MARK;
            3'd1:    b = REPORT_SIZE;
            3'd2:    b = REPORT_CMD;
            3'd3:    b = value;
            default: b = END_MARK;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/framed_serial_dimmer_controller.sv
// Flow: a request is registered at acceptance and processed once the result register is free;
// its first result transaction is offered in the cycle after it is processed.
// Throughput: one request per cycle when each gives a single result and the output does not
// stall; a report request holds the result register until all five frame bytes are taken.
// Reset (rst_n low, asynchronous): parser, timers, duty and error count take their
// reset values at once; configuration returns to 25 ms, 50 ms and step 1.
`include "framed_serial_dimmer_controller_macros.svh"

module framed_serial_dimmer_controller #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsdc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output fsdc_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data
);

    // Configuration registers; writes land at once, the port never stalls.
    fsdc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_period_ms  <= fsdc_pkg::ADC_PERIOD_RST;
            cfg_reg.fade_period_ms <= fsdc_pkg::FADE_PERIOD_RST;
            cfg_reg.fade_step      <= fsdc_pkg::FADE_STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fsdc_pkg::CFG_ADC_PERIOD:  cfg_reg.adc_period_ms  <= cfg_data;
                fsdc_pkg::CFG_FADE_PERIOD: cfg_reg.fade_period_ms <= cfg_data;
                fsdc_pkg::CFG_FADE_STEP:   cfg_reg.fade_step      <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Input register: take a new transaction when none is held or the held one moves on.
    logic               in_valid_reg;
    fsdc_pkg::in_item_t in_item_reg;
    logic               proc_fire;
    logic               tx_free;
    fsdc_pkg::run_t     run;

    assign proc_fire = in_valid_reg && tx_free;
    assign in_ready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
    end

    // Parser and dimmer state advance once per processed request.
    fsdc_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc_fire),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .run   (run)
    );

    // Result register; walks a report through its five bytes.
    fsdc_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_fire),
        .run       (run),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .free      (tx_free)
    );

    // A processed request always shows a result in the next cycle.
    `FSDC_ASSERT_NEXT(a_proc_gives_result, clk, rst_n, proc_fire, out_valid)
    // A held request does not change while the result side is busy.
    `FSDC_ASSERT_NEXT(a_held_request_stable, clk, rst_n, in_valid_reg && !proc_fire, in_valid_reg && $stable(in_item_reg))
    // A result without a frame byte is a lone result with a zero byte.
    `FSDC_ASSERT_NOW(a_idle_result_shape, clk, rst_n, out_valid && !out_item.frame_valid, out_item.last_of_run && (out_item.tx_byte == 8'd0))
    // Inside a report run the next byte follows directly.
    `FSDC_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && out_ready && !out_item.last_of_run, out_valid && out_item.frame_valid)

endmodule

// File: hw/rtl/fsdc_ctrl.sv
// Frame parser, tick timers and duty control of the dimmer controller.
module fsdc_ctrl #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  fsdc_pkg::in_item_t item,
    input  fsdc_pkg::cfg_t     cfg,
    output fsdc_pkg::run_t     run
);

    localparam int SW = $clog2(MAX_PAYLOAD);
    localparam logic [8:0] MAX_W = 9'(MAX_PAYLOAD);

    fsdc_pkg::phase_t phase_reg, phase_next;
    logic [SW-1:0] size_reg, size_next;
    logic [SW-1:0] count_reg, count_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  sleep_reg, sleep_next;
    logic [7:0]  duty_reg, duty_next;
    logic [8:0]  inc_reg, inc_next;
    logic [7:0]  pot_rep_reg, pot_rep_next;
    logic [7:0]  pot_last_reg, pot_last_next;
    logic [9:0]  adc_cnt_reg, adc_cnt_next;
    logic [9:0]  fade_cnt_reg, fade_cnt_next;
    logic        adc_due_reg, adc_due_next;
    logic        fade_due_reg, fade_due_next;
    logic [15:0] reject_reg, reject_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= fsdc_pkg::PH_WAIT;
            size_reg     <= '0;
            count_reg    <= '0;
            cmd_reg      <= '0;
            first_reg    <= '0;
            sleep_reg    <= '0;
            duty_reg     <= '0;
            inc_reg      <= fsdc_pkg::FADE_INC_RST;
            pot_rep_reg  <= '0;
            pot_last_reg <= '0;
            adc_cnt_reg  <= '0;
            fade_cnt_reg <= '0;
            adc_due_reg  <= 1'b0;
            fade_due_reg <= 1'b0;
            reject_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            size_reg     <= size_next;
            count_reg    <= count_next;
            cmd_reg      <= cmd_next;
            first_reg    <= first_next;
            sleep_reg    <= sleep_next;
            duty_reg     <= duty_next;
            inc_reg      <= inc_next;
            pot_rep_reg  <= pot_rep_next;
            pot_last_reg <= pot_last_next;
            adc_cnt_reg  <= adc_cnt_next;
            fade_cnt_reg <= fade_cnt_next;
            adc_due_reg  <= adc_due_next;
            fade_due_reg <= fade_due_next;
            reject_reg   <= reject_next;
        end
    end

    logic [SW-1:0] count_inc;
    logic [9:0]    adc_inc, fade_inc_cnt;
    logic          fade_due_now;
    logic [8:0]    inc_sel;
    logic signed [9:0] fade_sum;
    logic          rep_pot, rep_duty;

    assign count_inc    = count_reg + 1'b1;
    assign adc_inc      = adc_cnt_reg + 10'd1;
    assign fade_inc_cnt = fade_cnt_reg + 10'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        first_next    = first_reg;
        sleep_next    = sleep_reg;
        duty_next     = duty_reg;
        inc_next      = inc_reg;
        pot_rep_next  = pot_rep_reg;
        pot_last_next = pot_last_reg;
        adc_cnt_next  = adc_cnt_reg;
        fade_cnt_next = fade_cnt_reg;
        adc_due_next  = adc_due_reg;
        fade_due_next = fade_due_reg;
        reject_next   = reject_reg;
        rep_pot       = 1'b0;
        rep_duty      = 1'b0;
        fade_due_now  = fade_due_reg;
        inc_sel       = inc_reg;
        fade_sum      = '0;

        if (item.req_type == fsdc_pkg::REQ_BYTE)
        begin
            unique case (phase_reg)
                fsdc_pkg::PH_SIZE:
                begin
                    if ({1'b0, item.rx_byte} >= MAX_W)
                        phase_next = fsdc_pkg::PH_WAIT;
                    else
                    begin
                        size_next  = item.rx_byte[SW-1:0];
                        phase_next = fsdc_pkg::PH_CMD;
                    end
                end
                fsdc_pkg::PH_CMD:
                begin
                    cmd_next   = item.rx_byte;
                    phase_next = (size_reg != '0) ? fsdc_pkg::PH_DATA : fsdc_pkg::PH_END;
                end
                fsdc_pkg::PH_DATA:
                begin
                    if (count_reg == '0)
                        first_next = item.rx_byte;
                    count_next = count_inc;
                    if (count_inc == size_reg)
                        phase_next = fsdc_pkg::PH_END;
                end
                fsdc_pkg::PH_END:
                begin
                    phase_next = fsdc_pkg::PH_WAIT;
                    if (item.rx_byte == fsdc_pkg::END_MARK)
                    begin
                        unique case (cmd_reg)
                            fsdc_pkg::CMD_REPORT_POT:  rep_pot = 1'b1;
                            fsdc_pkg::CMD_SET_DUTY:
                            begin
                                if (item.switch_on)
                                    duty_next = first_reg;
                            end
                            fsdc_pkg::CMD_SET_SLEEP:   sleep_next = first_reg;
                            fsdc_pkg::CMD_REPORT_DUTY: rep_duty = 1'b1;
                            default: ;
                        endcase
                    end
                    else
                        reject_next = reject_reg + 16'd1;
                end
                default:
                begin
                    if (item.rx_byte == fsdc_pkg::START_MARK)
                    begin
                        phase_next = fsdc_pkg::PH_SIZE;
                        count_next = '0;
                    end
                end
            endcase
        end
        else if (item.req_type == fsdc_pkg::REQ_TICK)
        begin
            // Advance both period counters; fold back once when a period is due.
            adc_cnt_next = adc_inc;
            if (adc_inc >= cfg.adc_period_ms)
            begin
                adc_cnt_next = adc_inc - cfg.adc_period_ms;
                adc_due_next = 1'b1;
            end
            fade_cnt_next = fade_inc_cnt;
            if (fade_inc_cnt >= cfg.fade_period_ms)
            begin
                fade_cnt_next = fade_inc_cnt - cfg.fade_period_ms;
                fade_due_now  = 1'b1;
            end
            fade_due_next = fade_due_now;

            if (!item.switch_on)
            begin
                rep_duty = 1'b1;
                unique case (sleep_reg)
                    fsdc_pkg::SLEEP_OFF:  duty_next = 8'd0;
                    fsdc_pkg::SLEEP_FULL: duty_next = fsdc_pkg::DUTY_MAX;
                    fsdc_pkg::SLEEP_FADE:
                    begin
                        // Turn the fade around at either bound.
                        if (duty_reg <= 8'd1)
                            inc_sel = {2'b00, cfg.fade_step};
                        else if (duty_reg == fsdc_pkg::DUTY_MAX)
                            inc_sel = 9'd0 - {2'b00, cfg.fade_step};
                        inc_next = inc_sel;
                        if (fade_due_now)
                        begin
                            fade_due_next = 1'b0;
                            fade_sum = $signed({2'b00, duty_reg}) + $signed({inc_sel[8], inc_sel});
                            if (fade_sum < 10'sd0)
                                duty_next = 8'd0;
                            else if (fade_sum > 10'sd255)
                                duty_next = fsdc_pkg::DUTY_MAX;
                            else
                                duty_next = fade_sum[7:0];
                        end
                    end
                    fsdc_pkg::SLEEP_MIN:  duty_next = 8'd1;
                    default: ;
                endcase
            end
        end
        else if (item.req_type == fsdc_pkg::REQ_POT)
        begin
            if (item.switch_on && adc_due_reg)
            begin
                adc_due_next = 1'b0;
                if (item.pot_value != pot_last_reg)
                begin
                    pot_last_next = item.pot_value;
                    duty_next     = item.pot_value;
                    pot_rep_next  = item.pot_value;
                    rep_duty      = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        run.report      = rep_pot | rep_duty;
        run.value       = rep_pot ? pot_rep_reg : duty_next;
        run.duty        = duty_next;
        run.error_count = reject_next;
    end

endmodule

// File: hw/rtl/fsdc_tx.sv
// Result register and report serializer of the dimmer controller.
module fsdc_tx (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fsdc_pkg::run_t      run,
    input  logic                out_ready,
    output logic                out_valid,
    output fsdc_pkg::out_item_t out_item,
    output logic                free
);

    logic           valid_reg, valid_next;
    logic [2:0]     idx_reg, idx_next;
    fsdc_pkg::run_t run_reg;
    logic           last;

    assign last      = !run_reg.report || (idx_reg == fsdc_pkg::REPORT_LAST_IDX);
    assign free      = !valid_reg || (out_ready && last);
    assign out_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the run payload until the next item is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
            run_reg <= run;
    end

    always_comb
    begin
        out_item.duty        = run_reg.duty;
        out_item.frame_valid = run_reg.report;
        out_item.tx_byte     = run_reg.report ?
                               fsdc_pkg::report_byte(idx_reg, run_reg.value) : 8'd0;
        out_item.last_of_run = last;
        out_item.error_count = run_reg.error_count;
    end

endmodule

// File: test/framed_serial_dimmer_controller_test.sv
// Self-checking testbench for the framed serial dimmer controller.
`timescale 1ns / 1ps

module framed_serial_dimmer_controller_test;

    localparam int         MAX_PAYLOAD = 16;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         IDLE_PCT    = 35;
    // Request type that the block has no use for.
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    logic                logic_unused_guard;
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    fsdc_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fsdc_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [9:0]          cfg_data  = '0;

    // Requests waiting for the driver, and result transactions still owed by the block.
    fsdc_pkg::in_item_t  pending[$];
    fsdc_pkg::out_item_t tx_expect[$];

    // Set for a stretch of the run in which neither side ever idles.
    logic calm = 1'b0;

    int cycles   = 0;
    int queued   = 0;
    int sent     = 0;
    int checked  = 0;
    int failures = 0;
    int phases   = 0;

    // Shadow copy of the configuration registers.
    logic [9:0] cfg_adc  = fsdc_pkg::ADC_PERIOD_RST;
    logic [9:0] cfg_fade = fsdc_pkg::FADE_PERIOD_RST;
    logic [6:0] cfg_step = fsdc_pkg::FADE_STEP_RST;

    // Shadow copy of the controller state, starting from its reset values.
    fsdc_pkg::phase_t  phase      = fsdc_pkg::PH_WAIT;
    logic [7:0]        frm_size   = '0;
    logic [7:0]        frm_count  = '0;
    logic [7:0]        frm_cmd    = '0;
    logic [7:0]        first_pl   = '0;
    logic [7:0]        sleep_mode = '0;
    logic [7:0]        duty       = '0;
    logic signed [8:0] fade_inc   = fsdc_pkg::FADE_INC_RST;
    logic [7:0]        pot_rep    = '0;
    logic [7:0]        pot_last   = '0;
    logic [9:0]        adc_cnt    = '0;
    logic [9:0]        fade_cnt   = '0;
    logic              adc_due    = 1'b0;
    logic              fade_due   = 1'b0;
    logic [15:0]       rejects    = '0;

    assign logic_unused_guard = 1'b0;

    framed_serial_dimmer_controller #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Queue the five bytes of a report frame carrying value.
    task automatic queue_report(input logic [7:0] value);
        fsdc_pkg::out_item_t r;
        int k;
        for (k = 0; k < 5; k++)
        begin
            r.duty        = duty;
            r.frame_valid = 1'b1;
            case (k)
                0:       r.tx_byte = fsdc_pkg::START_MARK;
                1:       r.tx_byte = fsdc_pkg::REPORT_SIZE;
                2:       r.tx_byte = fsdc_pkg::REPORT_CMD;
                3:       r.tx_byte = value;
                default: r.tx_byte = fsdc_pkg::END_MARK;
            endcase
            r.last_of_run = (k == 4);
            r.error_count = rejects;
            tx_expect.push_back(r);
        end
    endtask

    // Queue the single quiet transaction of a request that sends no report.
    task automatic queue_quiet();
        fsdc_pkg::out_item_t r;
        r.duty        = duty;
        r.frame_valid = 1'b0;
        r.tx_byte     = '0;
        r.last_of_run = 1'b1;
        r.error_count = rejects;
        tx_expect.push_back(r);
    endtask

    // Advance the shadow state by one accepted request and queue what it causes.
    task automatic dimmer_predict(input fsdc_pkg::in_item_t it);
        logic       send;
        logic [7:0] value;
        logic [7:0] b;
        int         sum;
        send  = 1'b0;
        value = '0;
        b     = it.rx_byte;
        case (it.req_type)
            fsdc_pkg::REQ_BYTE:
            begin
                case (phase)
                    fsdc_pkg::PH_SIZE:
                    begin
                        // Oversized frames are dropped without counting an error.
                        if (b >= MAX_PAYLOAD)
                        begin
                            phase = fsdc_pkg::PH_WAIT;
                        end
                        else
                        begin
                            frm_size = b;
                            phase    = fsdc_pkg::PH_CMD;
                        end
                    end
                    fsdc_pkg::PH_CMD:
                    begin
                        frm_cmd = b;
                        phase   = (frm_size != 0) ? fsdc_pkg::PH_DATA : fsdc_pkg::PH_END;
                    end
                    fsdc_pkg::PH_DATA:
                    begin
                        if (frm_count == 0)
                            first_pl = b;
                        frm_count = frm_count + 8'd1;
                        if (frm_count == frm_size)
                            phase = fsdc_pkg::PH_END;
                    end
                    fsdc_pkg::PH_END:
                    begin
                        phase = fsdc_pkg::PH_WAIT;
                        if (b == fsdc_pkg::END_MARK)
                        begin
                            case (frm_cmd)
                                fsdc_pkg::CMD_REPORT_POT:
                                begin
                                    send  = 1'b1;
                                    value = pot_rep;
                                end
                                fsdc_pkg::CMD_SET_DUTY:
                                begin
                                    if (it.switch_on)
                                        duty = first_pl;
                                end
                                fsdc_pkg::CMD_SET_SLEEP:   sleep_mode = first_pl;
                                fsdc_pkg::CMD_REPORT_DUTY:
                                begin
                                    send  = 1'b1;
                                    value = duty;
                                end
                                default: ;
                            endcase
                        end
                        else
                        begin
                            rejects = rejects + 16'd1;
                        end
                    end
                    default:
                    begin
                        if (b == fsdc_pkg::START_MARK)
                        begin
                            phase     = fsdc_pkg::PH_SIZE;
                            frm_count = '0;
                        end
                    end
                endcase
            end
            fsdc_pkg::REQ_TICK:
            begin
                adc_cnt  = adc_cnt + 10'd1;
                fade_cnt = fade_cnt + 10'd1;
                if (adc_cnt >= cfg_adc)
                begin
                    adc_cnt = adc_cnt - cfg_adc;
                    adc_due = 1'b1;
                end
                if (fade_cnt >= cfg_fade)
                begin
                    fade_cnt = fade_cnt - cfg_fade;
                    fade_due = 1'b1;
                end
                if (!it.switch_on)
                begin
                    case (sleep_mode)
                        fsdc_pkg::SLEEP_OFF:  duty = 8'd0;
                        fsdc_pkg::SLEEP_FULL: duty = fsdc_pkg::DUTY_MAX;
                        fsdc_pkg::SLEEP_FADE:
                        begin
                            // Turn around at either bound, step only when the fade flag is up.
                            if (duty <= 8'd1)
                                fade_inc = $signed({2'b00, cfg_step});
                            if (duty == fsdc_pkg::DUTY_MAX)
                                fade_inc = -$signed({2'b00, cfg_step});
                            if (fade_due)
                            begin
                                fade_due = 1'b0;
                                sum = int'(duty) + int'(fade_inc);
                                if (sum < 0)
                                    sum = 0;
                                if (sum > 255)
                                    sum = 255;
                                duty = 8'(sum);
                            end
                        end
                        fsdc_pkg::SLEEP_MIN:  duty = 8'd1;
                        default: ;
                    endcase
                    send  = 1'b1;
                    value = duty;
                end
            end
            fsdc_pkg::REQ_POT:
            begin
                if (it.switch_on && adc_due)
                begin
                    adc_due = 1'b0;
                    if (it.pot_value != pot_last)
                    begin
                        pot_last = it.pot_value;
                        duty     = it.pot_value;
                        pot_rep  = it.pot_value;
                        send     = 1'b1;
                        value    = duty;
                    end
                end
            end
            default: ;
        endcase
        if (send)
            queue_report(value);
        else
            queue_quiet();
    endtask

    // Driver: predict each request at the edge that accepts it, then offer the next one
    // or, outside the calm stretch, idle at random. Hold valid and payload while a transaction is stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                dimmer_predict(in_item);
                sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_item  <= pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted result transaction with the oldest expectation,
    // and, outside the calm stretch, stall the output at random.
    always @(posedge clk)
    begin : monitor
        fsdc_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (tx_expect.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected result: duty %0d valid %0b byte %0d %s",
                                 $realtime, out_item.duty, out_item.frame_valid,
                                 out_item.tx_byte,
                                 $sformatf("last %0b errors %0d", out_item.last_of_run,
                                           out_item.error_count));
                end
                else
                begin
                    want = tx_expect.pop_front();
                    checked++;
                    if (out_item.duty !== want.duty || out_item.frame_valid !== want.frame_valid
                        || out_item.tx_byte !== want.tx_byte
                        || out_item.last_of_run !== want.last_of_run
                        || out_item.error_count !== want.error_count)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, checked);
                            $display("  expected duty %0d valid %0b byte %0d last %0b errors %0d",
                                     want.duty, want.frame_valid, want.tx_byte,
                                     want.last_of_run, want.error_count);
                            $display("  actual   duty %0d valid %0b byte %0d last %0b errors %0d",
                                     out_item.duty, out_item.frame_valid, out_item.tx_byte,
                                     out_item.last_of_run, out_item.error_count);
                        end
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run as failed once the cycle counter reaches its limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("framed_serial_dimmer_controller verification failed");
            $finish;
        end
    end

    // Append one request to the driver's queue.
    task automatic push(input logic [1:0] req, input logic [7:0] b, input logic [7:0] pot,
                        input logic sw);
        fsdc_pkg::in_item_t it;
        it.req_type  = req;
        it.rx_byte   = b;
        it.pot_value = pot;
        it.switch_on = sw;
        pending.push_back(it);
        queued++;
    endtask

    // Write one configuration register and mirror it once the transaction is taken.
    task automatic write_cfg(input logic [1:0] idx, input logic [9:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            fsdc_pkg::CFG_ADC_PERIOD:  cfg_adc  = data;
            fsdc_pkg::CFG_FADE_PERIOD: cfg_fade = data;
            fsdc_pkg::CFG_FADE_STEP:   cfg_step = data[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [9:0] adc, input logic [9:0] fade,
                             input logic [6:0] step);
        write_cfg(fsdc_pkg::CFG_ADC_PERIOD, adc);
        write_cfg(fsdc_pkg::CFG_FADE_PERIOD, fade);
        write_cfg(fsdc_pkg::CFG_FADE_STEP, {3'b000, step});
        phases++;
    endtask

    // Wait until every request is taken and every result has arrived, then let the
    // pipeline drain. Poll on the falling edge so the driver's updates at the rising
    // edge have settled.
    task automatic settle();
        @(negedge clk);
        while (pending.size() != 0 || in_valid || tx_expect.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly well-formed frames, tick bursts and pot sampling with random content;
    // the rest is noise, oversized and cut-off frames.
    task automatic gen_traffic(input int count);
        int         goal;
        int         pick;
        int         size;
        int         n;
        int         k;
        logic       sw;
        logic [7:0] cmd;
        logic [7:0] pot;
        goal = queued + count;
        pot  = 8'($urandom);
        while (queued < goal)
        begin
            pick = $urandom_range(0, 99);
            sw   = 1'($urandom_range(0, 1));
            if (pick < 38)
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
                cmd  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 255))
                                                   : 8'($urandom_range(0, 3));
                push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'($urandom), sw);
                push(fsdc_pkg::REQ_BYTE, 8'(size), 8'($urandom), sw);
                push(fsdc_pkg::REQ_BYTE, cmd, 8'($urandom), sw);
                for (k = 0; k < size; k++)
                begin
                    // Keep sleep mode payloads mostly inside the defined modes.
                    if (k == 0 && cmd == fsdc_pkg::CMD_SET_SLEEP && $urandom_range(0, 3) != 0)
                        push(fsdc_pkg::REQ_BYTE, 8'($urandom_range(0, 4)), 8'($urandom), sw);
                    else
                        push(fsdc_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), sw);
                end
                push(fsdc_pkg::REQ_BYTE,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : fsdc_pkg::END_MARK,
                     8'($urandom), sw);
            end
            else if (pick < 65)
            begin
                // Tick burst, switch off more often so the sleep modes run.
                sw = ($urandom_range(0, 9) < 4);
                n  = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    push(fsdc_pkg::REQ_TICK, 8'($urandom), 8'($urandom), sw);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(0, 4);
                for (k = 0; k < n; k++)
                    push(fsdc_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 1'b1);
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 3) != 0)
                        pot = 8'($urandom);
                    push(fsdc_pkg::REQ_POT, 8'($urandom), pot, ($urandom_range(0, 9) != 0));
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: push(fsdc_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), sw);
                    1: push(REQ_UNUSED, 8'($urandom), 8'($urandom), sw);
                    2:
                    begin
                        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'($urandom), sw);
                        push(fsdc_pkg::REQ_BYTE, 8'($urandom_range(MAX_PAYLOAD, 255)),
                             8'($urandom), sw);
                        push(fsdc_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), sw);
                    end
                    default:
                    begin
                        // Frame broken by a tick and then a start mark, which the parser takes as the command byte.
                        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'($urandom), sw);
                        push(fsdc_pkg::REQ_BYTE, 8'($urandom_range(0, 3)), 8'($urandom), sw);
                        push(fsdc_pkg::REQ_TICK, 8'($urandom), 8'($urandom), sw);
                        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'($urandom), sw);
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part: fastest timers and the largest step.
        configure(10'd1, 10'd1, 7'd127);
        // Switch off at reset: sleep off drives duty to zero and reports it.
        push(fsdc_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0);
        // Set duty to full scale, then read it back with an empty frame.
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'hFF, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'd1, 8'hFF, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::CMD_SET_DUTY, 8'hFF, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'hFF, 8'hFF, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::END_MARK, 8'hFF, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'd0, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::CMD_REPORT_DUTY, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::END_MARK, 8'h00, 1'b1);
        // Bad end mark counts an error.
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'd0, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::CMD_REPORT_DUTY, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'h00, 8'h00, 1'b1);
        // Size at the payload limit is dropped.
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'(MAX_PAYLOAD), 8'h00, 1'b1);
        // Raise the ADC flag, take a changed pot sample, then report the pot.
        push(fsdc_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_POT, 8'h00, 8'h80, 1'b1);
        push(fsdc_pkg::REQ_POT, 8'h00, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, 8'd0, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::CMD_REPORT_POT, 8'h00, 1'b1);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::END_MARK, 8'h00, 1'b1);
        push(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
        // Fade sleep mode, then a few ticks with the switch off.
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::START_MARK, 8'h00, 1'b0);
        push(fsdc_pkg::REQ_BYTE, 8'd1, 8'h00, 1'b0);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::CMD_SET_SLEEP, 8'h00, 1'b0);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::SLEEP_FADE, 8'h00, 1'b0);
        push(fsdc_pkg::REQ_BYTE, fsdc_pkg::END_MARK, 8'h00, 1'b0);
        repeat (3) push(fsdc_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0);
        settle();

        // Random part across several register settings.
        configure(10'd3, 10'd2, 7'd1);
        gen_traffic(110);
        settle();

        // Slowest timers, with no idling on either side.
        configure(10'd1023, 10'd1023, 7'd64);
        calm = 1'b1;
        gen_traffic(70);
        settle();
        calm = 1'b0;

        configure(10'd1, 10'd1, 7'd127);
        gen_traffic(115);
        settle();

        configure(10'd7, 10'd3, 7'd9);
        gen_traffic(115);
        settle();

        $display("Sent %0d requests over %0d register settings; %0d result transactions checked.",
                 sent, phases, checked);
        $display("Frames rejected for a bad end mark: %0d; failures: %0d.", rejects, failures);
        if (failures == 0)
            $display("framed_serial_dimmer_controller verification clean");
        else
            $display("framed_serial_dimmer_controller verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fsdc_pkg.sv
hw/rtl/fsdc_ctrl.sv
hw/rtl/fsdc_tx.sv
hw/rtl/framed_serial_dimmer_controller.sv
test/framed_serial_dimmer_controller_test.sv
